/* rtl/pfc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID feedforward controller package
// Shared types, constants and helper functions of the controller.
// ----------------------------------------------------------------------------
package pfc_pkg;

	// Sample period in Q16.16, range 1 to 65536.
	localparam int unsigned DT = 66;
	// Variable-speed integration bands in Q16.16.
	localparam int unsigned SPEED_A = 0;
	localparam int unsigned SPEED_B = 0;
	// One selects derivative on measurement.
	localparam bit DERIV_ON_MEAS = 1'b0;

	localparam logic [32:0] SPEED_AB   = 33'(SPEED_A) + 33'(SPEED_B);
	localparam logic [31:0] SPEED_B_W  = 32'(SPEED_B);
	localparam logic [30:0] SPEED_A_W  = 31'(SPEED_A);
	localparam logic [30:0] DT_W       = 31'(DT);
	localparam bit          SPEED_OFF  = (SPEED_A == 0) && (SPEED_B == 0);
	localparam logic [32:0] RATIO_ONE  = 33'd65536;

	localparam int MUL_W  = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int DIV_W  = 65;
	localparam int DVS_W  = 31;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_KP      = 3'd0;
	localparam logic [2:0] REG_KI      = 3'd1;
	localparam logic [2:0] REG_KD      = 3'd2;
	localparam logic [2:0] REG_KF      = 3'd3;
	localparam logic [2:0] REG_ILIMIT  = 3'd4;
	localparam logic [2:0] REG_OLIMIT  = 3'd5;
	localparam logic [2:0] REG_DZONE   = 3'd6;
	localparam logic [2:0] REG_SEPTHR  = 3'd7;

	typedef struct packed {
		logic signed [31:0] target;
		logic signed [31:0] measurement;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [31:0] integral;
	} result_t;

	typedef struct packed {
		logic                    start;
		logic signed [MUL_W-1:0] a;
		logic signed [MUL_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [PROD_W-1:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quot;
	} div_rsp_t;

	// Saturate a wide signed value to the 32-bit signed range.
	function automatic logic signed [31:0] sat32(input logic signed [66:0] x);
		logic signed [66:0] hi;
		logic signed [66:0] lo;
		hi = 67'sd2147483647;
		lo = -67'sd2147483648;
		if (x > hi) begin
			return 32'sh7fffffff;
		end else if (x < lo) begin
			return 32'sh80000000;
		end
		return x[31:0];
	endfunction

endpackage

/* rtl/pfc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Shift-and-add over one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pfc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  pfc_pkg::mul_req_t req,
	output pfc_pkg::mul_rsp_t rsp
);

	logic signed [pfc_pkg::MUL_W:0]   hi_q;
	logic        [pfc_pkg::MUL_W-1:0] lo_q;
	logic signed [pfc_pkg::MUL_W-1:0] a_q;
	logic        [5:0]                cnt_q;
	logic                             done_q;
	logic signed [pfc_pkg::MUL_W:0]   addend;
	logic signed [pfc_pkg::MUL_W:0]   sum;

	// The top multiplier bit carries negative weight, so it subtracts.
	always_comb begin
		addend = '0;
		if (lo_q[0]) begin
			addend = (cnt_q == 6'd1) ? -34'(a_q) : 34'(a_q);
		end
		sum = hi_q + addend;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == 6'd1);
			if (req.start) begin
				cnt_q <= 6'(pfc_pkg::MUL_W);
			end else if (cnt_q != 6'd0) begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q <= '0;
			lo_q <= req.b;
			a_q  <= req.a;
		end else if (cnt_q != 6'd0) begin
			hi_q <= {sum[pfc_pkg::MUL_W], sum[pfc_pkg::MUL_W:1]};
			lo_q <= {sum[0], lo_q[pfc_pkg::MUL_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = {hi_q[pfc_pkg::MUL_W-1:0], lo_q};

endmodule

/* rtl/pfc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfc_pkg::div_req_t req,
	output pfc_pkg::div_rsp_t rsp
);

	logic [pfc_pkg::DIV_W-1:0] q_q;
	logic [pfc_pkg::DVS_W-1:0] rem_q;
	logic [pfc_pkg::DVS_W-1:0] dvs_q;
	logic [6:0]                cnt_q;
	logic                      done_q;
	logic [pfc_pkg::DVS_W:0]   trial;
	logic                      fits;

	always_comb begin
		trial = {rem_q, q_q[pfc_pkg::DIV_W-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= !req.start && (cnt_q == 7'd1);
			if (req.start) begin
				cnt_q <= 7'(pfc_pkg::DIV_W);
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			q_q   <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (cnt_q != 7'd0) begin
			rem_q <= fits ? 31'(trial - {1'b0, dvs_q}) : trial[pfc_pkg::DVS_W-1:0];
			q_q   <= {q_q[pfc_pkg::DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;

endmodule

/* rtl/pid_feedforward_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller with feedforward
// Q16.16 PID with dead zone, variable-speed and separated integral, clamps.
// ----------------------------------------------------------------------------
// Each item (target, measurement) yields one item (drive, integral). A
// sequencer runs the terms through one bit-serial multiplier and one
// bit-serial divider. A separated integral takes three products and one
// divide, other items six products and one divide; inside the
// variable-speed band the speed ratio needs a second divide. A new item
// can be accepted in the cycle after the result is registered, even while
// that result still waits in the output register; the following result
// then waits until the first one is taken.
module pid_feedforward_controller_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             sample_valid,
	output logic             sample_ready,
	input  pfc_pkg::sample_t sample,
	output logic             result_valid,
	input  logic             result_ready,
	output pfc_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b00000000001,
		ST_PREP    = 11'b00000000010,
		ST_MUL_P   = 11'b00000000100,
		ST_DIV_R   = 11'b00000001000,
		ST_MUL_STP = 11'b00000010000,
		ST_MUL_INC = 11'b00000100000,
		ST_MUL_I   = 11'b00001000000,
		ST_MUL_D   = 11'b00010000000,
		ST_DIV_D   = 11'b00100000000,
		ST_MUL_F   = 11'b01000000000,
		ST_FIN     = 11'b10000000000
	} state_t;

	state_t state_q;
	state_t state_prev_q;
	logic   launch;

	logic signed [31:0] kp_q, ki_q, kd_q, kf_q;
	logic        [30:0] ilim_q, olim_q, dzone_q, septhr_q;

	logic signed [31:0] tgt_q, meas_q, err_q;
	logic        [31:0] aerr_q;
	logic signed [31:0] error_sum_q, last_err_q, last_tgt_q, last_meas_q;
	logic signed [32:0] step_q;
	logic signed [33:0] acc_q;
	logic               dsign_q;
	logic        [64:0] dmag_q;
	logic               res_valid_q;
	pfc_pkg::result_t   res_q;

	pfc_pkg::mul_req_t mul_req;
	pfc_pkg::mul_rsp_t mul_rsp;
	pfc_pkg::div_req_t div_req;
	pfc_pkg::div_rsp_t div_rsp;

	logic signed [32:0] diff;
	logic signed [31:0] e_sat;
	logic        [31:0] e_abs;
	logic               sep;
	logic signed [31:0] prod_term;
	logic signed [31:0] d_term;
	logic signed [33:0] lim_sum;
	logic signed [31:0] drive;
	logic signed [31:0] es_clamped;
	logic signed [32:0] ilim_s, olim_s;

	pfc_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	pfc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// A unit is started in the first cycle of each state that uses it.
	assign launch = (state_q != state_prev_q);

	always_comb begin
		diff  = 33'(tgt_q) - 33'(meas_q);
		e_sat = pfc_pkg::sat32(67'(diff));
		e_abs = e_sat[31] ? 32'(-33'(e_sat)) : 32'(e_sat);
		sep   = (septhr_q != '0) && (aerr_q >= {1'b0, septhr_q});
		ilim_s = 33'({2'b00, ilim_q});
		olim_s = 33'({2'b00, olim_q});

		es_clamped = error_sum_q;
		if (ilim_q != '0) begin
			if (33'(error_sum_q) > ilim_s) begin
				es_clamped = ilim_s[31:0];
			end else if (33'(error_sum_q) < -ilim_s) begin
				es_clamped = 32'(-ilim_s);
			end
		end

		prod_term = pfc_pkg::sat32(67'(mul_rsp.prod >>> 16));
		d_term    = pfc_pkg::sat32(dsign_q ? -67'({2'b00, div_rsp.quot})
		                                   : 67'({2'b00, div_rsp.quot}));

		lim_sum = acc_q;
		if (olim_q != '0) begin
			if (acc_q > 34'(olim_s)) begin
				lim_sum = 34'(olim_s);
			end else if (acc_q < -34'(olim_s)) begin
				lim_sum = -34'(olim_s);
			end
		end
		drive = pfc_pkg::sat32(67'(lim_sum));
	end

	// Operand selection for the shared units.
	always_comb begin
		mul_req.start = launch && (state_q == ST_MUL_P || state_q == ST_MUL_STP ||
			state_q == ST_MUL_INC || state_q == ST_MUL_I || state_q == ST_MUL_D ||
			state_q == ST_MUL_F);
		mul_req.a = 33'(kp_q);
		mul_req.b = 33'(err_q);
		case (state_q)
			ST_MUL_STP: begin
				mul_req.a = step_q;
				mul_req.b = 33'(pfc_pkg::DT);
			end
			ST_MUL_INC: begin
				mul_req.a = step_q;
				mul_req.b = 33'(err_q);
			end
			ST_MUL_I: begin
				mul_req.a = 33'(ki_q);
				mul_req.b = 33'(error_sum_q);
			end
			ST_MUL_D: begin
				mul_req.a = 33'(kd_q);
				mul_req.b = pfc_pkg::DERIV_ON_MEAS ? 33'(last_meas_q) - 33'(meas_q)
				                                   : 33'(err_q) - 33'(last_err_q);
			end
			ST_MUL_F: begin
				mul_req.a = 33'(kf_q);
				mul_req.b = 33'(tgt_q) - 33'(last_tgt_q);
			end
			default: begin
			end
		endcase

		div_req.start = launch && (state_q == ST_DIV_R || state_q == ST_DIV_D);
		if (state_q == ST_DIV_R) begin
			div_req.dividend = 65'(pfc_pkg::SPEED_AB - {1'b0, aerr_q}) << 16;
			div_req.divisor  = pfc_pkg::SPEED_A_W;
		end else begin
			div_req.dividend = dmag_q;
			div_req.divisor  = pfc_pkg::DT_W;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q     <= '0;
			ki_q     <= '0;
			kd_q     <= '0;
			kf_q     <= '0;
			ilim_q   <= '0;
			olim_q   <= '0;
			dzone_q  <= '0;
			septhr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pfc_pkg::REG_KP:     kp_q     <= cfg_data;
				pfc_pkg::REG_KI:     ki_q     <= cfg_data;
				pfc_pkg::REG_KD:     kd_q     <= cfg_data;
				pfc_pkg::REG_KF:     kf_q     <= cfg_data;
				pfc_pkg::REG_ILIMIT: ilim_q   <= cfg_data[30:0];
				pfc_pkg::REG_OLIMIT: olim_q   <= cfg_data[30:0];
				pfc_pkg::REG_DZONE:  dzone_q  <= cfg_data[30:0];
				pfc_pkg::REG_SEPTHR: septhr_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			state_prev_q <= ST_IDLE;
			res_valid_q  <= 1'b0;
			error_sum_q  <= '0;
			last_err_q   <= '0;
			last_tgt_q   <= '0;
			last_meas_q  <= '0;
		end else begin
			state_prev_q <= state_q;
			if (state_q == ST_FIN && (!res_valid_q || result_ready)) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					error_sum_q <= es_clamped;
					state_q     <= ST_MUL_P;
				end
				ST_MUL_P: begin
					if (mul_rsp.done) begin
						if (sep) begin
							error_sum_q <= '0;
							state_q     <= ST_MUL_D;
						end else if (pfc_pkg::SPEED_OFF || aerr_q <= pfc_pkg::SPEED_B_W) begin
							state_q <= ST_MUL_STP;
						end else if ({1'b0, aerr_q} < pfc_pkg::SPEED_AB) begin
							state_q <= ST_DIV_R;
						end else begin
							state_q <= ST_MUL_STP;
						end
					end
				end
				ST_DIV_R: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL_STP;
					end
				end
				ST_MUL_STP: begin
					if (mul_rsp.done) begin
						state_q <= ST_MUL_INC;
					end
				end
				ST_MUL_INC: begin
					if (mul_rsp.done) begin
						error_sum_q <= pfc_pkg::sat32(67'(error_sum_q) +
							67'(mul_rsp.prod >>> 16));
						state_q     <= ST_MUL_I;
					end
				end
				ST_MUL_I: begin
					if (mul_rsp.done) begin
						state_q <= ST_MUL_D;
					end
				end
				ST_MUL_D: begin
					if (mul_rsp.done) begin
						state_q <= ST_DIV_D;
					end
				end
				ST_DIV_D: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL_F;
					end
				end
				ST_MUL_F: begin
					if (mul_rsp.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || result_ready) begin
						last_meas_q <= meas_q;
						last_tgt_q  <= tgt_q;
						last_err_q  <= err_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					tgt_q  <= sample.target;
					meas_q <= sample.measurement;
				end
			end
			ST_PREP: begin
				// Inside the dead zone the target is taken to equal the measurement.
				if (e_abs < {1'b0, dzone_q}) begin
					err_q  <= '0;
					aerr_q <= '0;
					tgt_q  <= meas_q;
				end else begin
					err_q  <= e_sat;
					aerr_q <= e_abs;
				end
			end
			ST_MUL_P: begin
				if (mul_rsp.done) begin
					acc_q  <= 34'(prod_term);
					step_q <= (!(pfc_pkg::SPEED_OFF || aerr_q <= pfc_pkg::SPEED_B_W) &&
						!({1'b0, aerr_q} < pfc_pkg::SPEED_AB)) ? '0 : pfc_pkg::RATIO_ONE;
				end
			end
			ST_DIV_R: begin
				if (div_rsp.done) begin
					step_q <= 33'(div_rsp.quot[16:0]);
				end
			end
			ST_MUL_STP: begin
				if (mul_rsp.done) begin
					step_q <= 33'(mul_rsp.prod >>> 16);
				end
			end
			ST_MUL_I: begin
				if (mul_rsp.done) begin
					acc_q <= acc_q + 34'(prod_term);
				end
			end
			ST_MUL_D: begin
				if (mul_rsp.done) begin
					dsign_q <= mul_rsp.prod[pfc_pkg::PROD_W-1];
					dmag_q  <= mul_rsp.prod[pfc_pkg::PROD_W-1] ? 65'(-mul_rsp.prod)
					                                          : 65'(mul_rsp.prod);
				end
			end
			ST_DIV_D: begin
				if (div_rsp.done) begin
					acc_q <= acc_q + 34'(d_term);
				end
			end
			ST_MUL_F: begin
				if (mul_rsp.done) begin
					acc_q <= acc_q + 34'(prod_term);
				end
			end
			ST_FIN: begin
				if (!res_valid_q || result_ready) begin
					res_q.drive    <= drive;
					res_q.integral <= error_sum_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign sample_ready = (state_q == ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

/* rtl/pfc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID feedforward controller checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module pfc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             sample_valid,
	input logic             sample_ready,
	input logic             result_valid,
	input logic             result_ready,
	input pfc_pkg::result_t result
);

	// One item is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample_ready stayed high after an item was accepted");

	// A new result only rises when the unit was not idle just before it.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> !$past(sample_ready))
		else $error("result appeared without a finished computation");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result_valid dropped before the item was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result payload changed while stalled");

endmodule

bind pid_feedforward_controller_unit pfc_checker u_pfc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.sample_valid(sample_valid),
	.sample_ready(sample_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID feedforward controller testbench
// Drives (target, measurement) items through several gain and limit settings,
// predicts each (drive, integral) result in the bench and compares them.
// ----------------------------------------------------------------------------
module tb_top;

	logic             clk;
	logic             arst_n;
	logic             sample_valid;
	logic             sample_ready;
	pfc_pkg::sample_t sample;
	logic             result_valid;
	logic             result_ready;
	pfc_pkg::result_t result;
	logic             cfg_we;
	logic [2:0]       cfg_index;
	logic [31:0]      cfg_data;

	pid_feedforward_controller_unit dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Controller state and registers as the bench sees them.
	logic signed [31:0] gain_p, gain_i, gain_d, gain_f;
	longint lim_int, lim_out, zone, sep_thr;
	logic signed [31:0] acc_err = 0;
	logic signed [31:0] prev_err = 0;
	logic signed [31:0] prev_tgt = 0;
	logic signed [31:0] prev_meas = 0;

	pfc_pkg::sample_t samples_pending[$];
	pfc_pkg::result_t drives_expected[$];
	int      n_errors = 0;
	int      n_results = 0;
	int      n_sent;
	bit      hold_sender;
	bit      hold_rx_req;
	bit      hold_rx_done;
	bit      burst_on;
	int      burst_left;
	int      stall_cnt;
	int      long_hold;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic longint sat_w(input longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Floor division by 65536.
	function automatic longint floor16(input longint x);
		return x >>> 16;
	endfunction

	// 64-bit product kept exact: both operands fit in 33 bits.
	function automatic pfc_pkg::result_t predict_drive(input pfc_pkg::sample_t s);
		longint tgt, meas, err, aerr, ratio, pt, it, dtm, ft, sum, stp, acc;
		pfc_pkg::result_t r;
		tgt  = longint'(s.target);
		meas = longint'(s.measurement);
		err  = sat_w(tgt - meas);
		aerr = err < 0 ? -err : err;
		if (aerr < zone) begin
			tgt = meas;
			err = 0;
			aerr = 0;
		end
		pt = sat_w(floor16(longint'(gain_p) * err));
		if (pfc_pkg::SPEED_A == 0 && pfc_pkg::SPEED_B == 0) ratio = 65536;
		else if (aerr <= longint'(pfc_pkg::SPEED_B)) ratio = 65536;
		else if (aerr < longint'(pfc_pkg::SPEED_A) + longint'(pfc_pkg::SPEED_B))
			ratio = ((longint'(pfc_pkg::SPEED_A) + longint'(pfc_pkg::SPEED_B) - aerr) * 65536)
				/ longint'(pfc_pkg::SPEED_A);
		else ratio = 0;
		acc = longint'(acc_err);
		if (lim_int != 0) begin
			if (acc > lim_int) acc = lim_int;
			if (acc < -lim_int) acc = -lim_int;
		end
		if (sep_thr == 0 || aerr < sep_thr) begin
			stp = (ratio * longint'(pfc_pkg::DT)) >>> 16;
			acc = sat_w(acc + floor16(stp * err));
			it = sat_w(floor16(longint'(gain_i) * acc));
		end else begin
			acc = 0;
			it = 0;
		end
		// Signed division truncates toward zero, as required.
		if (pfc_pkg::DERIV_ON_MEAS)
			dtm = sat_w((longint'(gain_d) * (longint'(prev_meas) - meas))
				/ longint'(pfc_pkg::DT));
		else
			dtm = sat_w((longint'(gain_d) * (err - longint'(prev_err)))
				/ longint'(pfc_pkg::DT));
		ft = sat_w(floor16(longint'(gain_f) * (tgt - longint'(prev_tgt))));
		sum = pt + it + dtm + ft;
		if (lim_out != 0) begin
			if (sum > lim_out) sum = lim_out;
			if (sum < -lim_out) sum = -lim_out;
		end
		sum = sat_w(sum);
		acc_err   = acc[31:0];
		prev_meas = meas[31:0];
		prev_tgt  = tgt[31:0];
		prev_err  = err[31:0];
		r.drive    = sum[31:0];
		r.integral = acc[31:0];
		return r;
	endfunction

	// Driver: bursts of random length, random gaps, optional hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			burst_on <= 1'b0;
			burst_left <= 0;
			n_sent <= 0;
		end else begin
			if (sample_valid && sample_ready) begin
				drives_expected.push_back(predict_drive(sample));
				n_sent <= n_sent + 1;
			end
			if (!sample_valid || sample_ready) begin
				if (burst_left == 0) begin
					burst_on <= !burst_on;
					burst_left <= $urandom_range(burst_on ? 12 : 30, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
				if (burst_on && !hold_sender && samples_pending.size() > 0) begin
					sample_valid <= 1'b1;
					sample <= samples_pending.pop_front();
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off when requested.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_cnt <= 0;
			long_hold <= 0;
			hold_rx_done <= 1'b0;
		end else begin
			if (hold_rx_req && !hold_rx_done) begin
				result_ready <= 1'b0;
				long_hold <= 3000;
				hold_rx_done <= 1'b1;
			end else if (long_hold > 0) begin
				result_ready <= 1'b0;
				long_hold <= long_hold - 1;
			end else if (stall_cnt > 0) begin
				result_ready <= 1'b0;
				stall_cnt <= stall_cnt - 1;
			end else if ($urandom_range(7, 0) == 0) begin
				result_ready <= 1'b0;
				stall_cnt <= $urandom_range(40, 1);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		pfc_pkg::result_t e;
		if (arst_n && result_valid && result_ready) begin
			n_results <= n_results + 1;
			if (drives_expected.size() == 0) begin
				$error("unexpected result drive=%0d integral=%0d",
					result.drive, result.integral);
				n_errors++;
			end else begin
				e = drives_expected.pop_front();
				if (result.drive !== e.drive) begin
					$error("drive: expected %0d, actual %0d", e.drive, result.drive);
					n_errors++;
				end
				if (result.integral !== e.integral) begin
					$error("integral: expected %0d, actual %0d",
						e.integral, result.integral);
					n_errors++;
				end
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		longint u31;
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		u31 = longint'(val[30:0]);
		case (idx)
			pfc_pkg::REG_KP:     gain_p = val;
			pfc_pkg::REG_KI:     gain_i = val;
			pfc_pkg::REG_KD:     gain_d = val;
			pfc_pkg::REG_KF:     gain_f = val;
			pfc_pkg::REG_ILIMIT: lim_int = u31;
			pfc_pkg::REG_OLIMIT: lim_out = u31;
			pfc_pkg::REG_DZONE:  zone = u31;
			pfc_pkg::REG_SEPTHR: sep_thr = u31;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (samples_pending.size() > 0 || sample_valid || drives_expected.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_val(input int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(1 << 21, 0)) - (1 << 20));
			2: return 32'($signed($urandom_range(1 << 17, 0)) - (1 << 16));
			default: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	task automatic push_item(input logic [31:0] t, input logic [31:0] m);
		pfc_pkg::sample_t s;
		s.target = t;
		s.measurement = m;
		samples_pending.push_back(s);
	endtask

	function automatic logic [31:0] rand_small_limit();
		return $urandom_range(1, 0) ? 32'($urandom_range(1 << 20, 0)) : $urandom();
	endfunction

	initial begin
		int ph, k, mode;
		logic [31:0] base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = pfc_pkg::REG_KP;
		cfg_data = '0;
		gain_p = 0; gain_i = 0; gain_d = 0; gain_f = 0;
		lim_int = 0; lim_out = 0; zone = 0; sep_thr = 0;
		hold_sender = 0; hold_rx_req = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: moderate gains, then field extremes and the special cases.
		write_reg(pfc_pkg::REG_KP, 32'h0001_8000);
		write_reg(pfc_pkg::REG_KI, 32'h0000_4000);
		write_reg(pfc_pkg::REG_KD, 32'h0002_0000);
		write_reg(pfc_pkg::REG_KF, 32'hffff_0000);
		write_reg(pfc_pkg::REG_ILIMIT, 32'h0000_0000);
		write_reg(pfc_pkg::REG_OLIMIT, 32'h0000_0000);
		write_reg(pfc_pkg::REG_DZONE, 32'h0000_0000);
		write_reg(pfc_pkg::REG_SEPTHR, 32'h0000_0000);
		push_item(32'h0, 32'h0);
		push_item(32'h7fffffff, 32'h80000000);
		push_item(32'h80000000, 32'h7fffffff);
		push_item(32'h7fffffff, 32'h7fffffff);
		push_item(32'h80000000, 32'h80000000);
		push_item(32'h0001_0000, 32'h0);
		push_item(32'hffff_0000, 32'h0);
		wait_drained();
		// Dead zone, separation, clamps and extreme gains.
		write_reg(pfc_pkg::REG_DZONE, 32'h0000_8000);
		write_reg(pfc_pkg::REG_SEPTHR, 32'h0010_0000);
		write_reg(pfc_pkg::REG_ILIMIT, 32'h0000_0100);
		write_reg(pfc_pkg::REG_OLIMIT, 32'h0002_0000);
		write_reg(pfc_pkg::REG_KP, 32'h7fffffff);
		write_reg(pfc_pkg::REG_KI, 32'h80000000);
		push_item(32'h0000_4000, 32'h0);
		push_item(32'h0000_8000, 32'h0);
		push_item(32'h0010_0000, 32'h0);
		push_item(32'h000f_ffff, 32'h0);
		push_item(32'h0, 32'h0010_0000);
		push_item(32'h1234_5678, 32'h1234_0000);
		wait_drained();
		write_reg(pfc_pkg::REG_DZONE, 32'h7fffffff);
		write_reg(pfc_pkg::REG_SEPTHR, 32'h7fffffff);
		write_reg(pfc_pkg::REG_ILIMIT, 32'h7fffffff);
		write_reg(pfc_pkg::REG_OLIMIT, 32'h7fffffff);
		push_item(32'h7fffffff, 32'h80000000);
		push_item(32'h0000_0001, 32'h0);
		push_item(32'h4000_0000, 32'hc000_0000);
		wait_drained();

		// Random phases with fresh settings; phase 2 uses a long receiver hold.
		for (ph = 0; ph < 8; ph++) begin
			mode = ph % 4;
			write_reg(pfc_pkg::REG_KP, rand_val(ph == 7 ? 0 : 2));
			write_reg(pfc_pkg::REG_KI, rand_val(ph == 6 ? 3 : 2));
			write_reg(pfc_pkg::REG_KD, rand_val(ph == 5 ? 0 : 2));
			write_reg(pfc_pkg::REG_KF, rand_val(2));
			write_reg(pfc_pkg::REG_ILIMIT, ph == 0 ? 32'h0 : rand_small_limit());
			write_reg(pfc_pkg::REG_OLIMIT, ph == 1 ? 32'h0 : rand_small_limit());
			write_reg(pfc_pkg::REG_DZONE, ph < 2 ? 32'h0 : 32'($urandom_range(1 << 16, 0)));
			write_reg(pfc_pkg::REG_SEPTHR,
				ph == 3 ? 32'h0 : 32'($urandom_range(1 << 21, 1)));
			base = $urandom();
			for (k = 0; k < 150; k++) begin
				if (mode == 1)
					push_item(base + rand_val(1), base + rand_val(2));
				else
					push_item(rand_val($urandom_range(3, 0)), rand_val($urandom_range(3, 0)));
			end
			if (ph == 2) hold_rx_req = 1;
			if (ph == 4) begin
				// Sender pauses midway until every result is back.
				while (samples_pending.size() > 75) @(posedge clk);
				hold_sender = 1;
				while (sample_valid || drives_expected.size() > 0) @(posedge clk);
				hold_sender = 0;
			end
			wait_drained();
		end
		$display("Covered %0d items, %0d results over 11 register settings.",
			n_sent, n_results);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/pfc_pkg.sv
rtl/pfc_mul.sv
rtl/pfc_div.sv
rtl/pid_feedforward_controller_unit.sv
rtl/pfc_checker.sv
sim/tb_top.sv
